// ===== sv/ubxack_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxack_pkg
// Shared types, codes and ACK frame helpers for the UBX command/ACK unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ubxack_pkg;

  // Input request kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_RX   = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Result kinds
  localparam logic OUT_TX     = 1'b0;
  localparam logic OUT_STATUS = 1'b1;

  // Command status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_ACK      = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_TIMEOUT      = 2'd0;
  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd1;
  localparam logic [1:0] REG_RESTART      = 2'd2;

  // UBX ACK-ACK frame constants
  localparam logic [7:0] UBX_SYNC_1      = 8'hB5;
  localparam logic [7:0] UBX_SYNC_2      = 8'h62;
  localparam logic [7:0] ACK_MSG_CLASS   = 8'h05;
  localparam logic [7:0] ACK_MSG_ID      = 8'h01;
  localparam logic [7:0] ACK_PAYLOAD_LEN = 8'h02;
  localparam logic [3:0] ACK_LEN         = 4'd10;
  localparam int         ACK_SUM_BYTES   = 6;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_RX,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       fend;
  } cmd_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [3:0]  max_attempts;
    logic        restart_on_mismatch;
  } cfg_t;

  // Fletcher-8 over the checked part of the ACK frame; returns {ck_b, ck_a}
  function automatic logic [15:0] ack_checksum(input logic [7:0] cls, input logic [7:0] id);
    logic [7:0] msg [ACK_SUM_BYTES];
    logic [7:0] a;
    logic [7:0] b;
    msg[0] = ACK_MSG_CLASS;
    msg[1] = ACK_MSG_ID;
    msg[2] = ACK_PAYLOAD_LEN;
    msg[3] = 8'h00;
    msg[4] = cls;
    msg[5] = id;
    a = 8'h00;
    b = 8'h00;
    for (int i = 0; i < ACK_SUM_BYTES; i++) begin
      a = a + msg[i];
      b = b + a;
    end
    return {b, a};
  endfunction

  // Expected byte of the ACK-ACK frame at a given position
  function automatic logic [7:0] ack_byte(input logic [3:0] idx, input logic [7:0] cls,
                                          input logic [7:0] id, input logic [7:0] ck_a,
                                          input logic [7:0] ck_b);
    logic [7:0] res;
    case (idx)
      4'd0:    res = UBX_SYNC_1;
      4'd1:    res = UBX_SYNC_2;
      4'd2:    res = ACK_MSG_CLASS;
      4'd3:    res = ACK_MSG_ID;
      4'd4:    res = ACK_PAYLOAD_LEN;
      4'd5:    res = 8'h00;
      4'd6:    res = cls;
      4'd7:    res = id;
      4'd8:    res = ck_a;
      default: res = ck_b;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ubx_command_ack_handshake_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_command_ack_handshake_unit
// Sends a UBX command frame with its Fletcher checksum, waits for the
// matching ACK-ACK frame and resends the stored frame on timeout.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake        Payload
//   in_      request    in_valid/ready   in_kind, in_data, in_frame_end
//   out_     result     out_valid/ready  out_kind, out_tx_byte, out_status,
//                                        out_run_last
//   cfg      APB write  psel/penable     timeout, max attempts, restart mode
//
// A command byte goes through S_IDLE and S_DATA, at frame end the checksum
// bytes through S_CK_A and S_CK_B; received bytes and ticks are handled in
// S_IDLE, a status in S_STATUS. A retry replays the stored frame from the
// frame RAM byte by byte (registered read in S_RD, then output in S_RP) and
// takes no new request until done. A two-entry request queue keeps input
// flowing while the engine works or the result register is stalled. Reset is
// synchronous; the frame RAM is not cleared and only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_command_ack_handshake_unit #(
  parameter int FRAME_MAX = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_data,
  input  wire logic        in_frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_tx_byte,
  output logic [1:0]       out_status,
  output logic             out_run_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0]      timeout_r;
  logic [3:0]       max_attempts_r;
  logic             restart_r;
  logic             cfg_wr;
  ubxack_pkg::cfg_t cfg;
  logic             cmd_valid;
  ubxack_pkg::cmd_t cmd;
  logic             cmd_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r      <= 16'd1;
      max_attempts_r <= 4'd4;
      restart_r      <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ubxack_pkg::REG_TIMEOUT:      timeout_r      <= pwdata[15:0];
        ubxack_pkg::REG_MAX_ATTEMPTS: max_attempts_r <= pwdata[3:0];
        ubxack_pkg::REG_RESTART:      restart_r      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ubxack_pkg::REG_TIMEOUT:      prdata = {16'h0000, timeout_r};
      ubxack_pkg::REG_MAX_ATTEMPTS: prdata = {28'h0000000, max_attempts_r};
      ubxack_pkg::REG_RESTART:      prdata = {31'h00000000, restart_r};
      default:                      prdata = 32'h00000000;
    endcase
  end

  assign cfg = '{timeout_ticks: timeout_r, max_attempts: max_attempts_r,
                 restart_on_mismatch: restart_r};

  ubxack_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_data      (in_data),
    .in_frame_end (in_frame_end),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  ubxack_back #(
    .FRAME_MAX (FRAME_MAX)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .cfg_i        (cfg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_tx_byte  (out_tx_byte),
    .out_status   (out_status),
    .out_run_last (out_run_last)
  );

endmodule

`default_nettype wire

// ===== sv/ubxack_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxack_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxack_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ubxack_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxack_front
// Accepts input requests, classifies them by kind and queues them for the
// command engine. Requests of an unused kind are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxack_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_kind,
  input  wire logic [7:0]        in_data,
  input  wire logic              in_frame_end,
  output logic                   cmd_valid_o,
  output ubxack_pkg::cmd_t       cmd_o,
  input  wire logic              cmd_pop_i
);

  localparam int PTR_W = (ubxack_pkg::QUEUE_DEPTH > 1) ? $clog2(ubxack_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ubxack_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ubxack_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ubxack_pkg::QUEUE_DEPTH);

  ubxack_pkg::cmd_t   queue_r [ubxack_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  logic               keep;
  ubxack_pkg::op_t    op;
  logic               push;
  logic               pop;

  always_comb begin
    keep = 1'b1;
    op   = ubxack_pkg::OP_LOAD;
    case (in_kind)
      ubxack_pkg::KIND_CMD:  op = ubxack_pkg::OP_LOAD;
      ubxack_pkg::KIND_RX:   op = ubxack_pkg::OP_RX;
      ubxack_pkg::KIND_TICK: op = ubxack_pkg::OP_TICK;
      default:               keep = 1'b0;
    endcase
  end

  assign in_ready    = (count_r != CNT_FULL);
  assign push        = in_valid && in_ready && keep;
  assign cmd_valid_o = (count_r != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        queue_r[wr_ptr_r] <= '{op: op, data: in_data, fend: in_frame_end};
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ubxack_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxack_back
// Command engine: stores and forwards the command frame, appends its
// checksum, matches the ACK-ACK frame, counts ticks and replays on timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxack_back #(
  parameter int FRAME_MAX = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_valid_i,
  input  wire ubxack_pkg::cmd_t cmd_i,
  output logic                  cmd_pop_o,
  input  wire ubxack_pkg::cfg_t cfg_i,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_kind,
  output logic [7:0]            out_tx_byte,
  output logic [1:0]            out_status,
  output logic                  out_run_last
);

  localparam int LEN_W  = $clog2(FRAME_MAX + 1);
  localparam int ADDR_W = $clog2(FRAME_MAX);
  localparam logic [LEN_W-1:0] STORE_LIM = LEN_W'(FRAME_MAX - 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA,
    S_CK_A,
    S_CK_B,
    S_RD,
    S_RP,
    S_STATUS
  } state_t;

  typedef enum logic {
    PH_LOAD,
    PH_ACK
  } phase_t;

  state_t            state_r;
  phase_t            phase_r;
  logic [LEN_W-1:0]  len_r;
  logic [7:0]        sum_a_r;
  logic [7:0]        sum_b_r;
  logic [7:0]        ack_class_r;
  logic [7:0]        ack_id_r;
  logic [7:0]        ack_sum_a_r;
  logic [7:0]        ack_sum_b_r;
  logic [3:0]        match_r;
  logic [15:0]       tick_r;
  logic [3:0]        attempt_r;
  logic [7:0]        byte_r;
  logic              fend_r;
  logic [ADDR_W-1:0] idx_r;
  logic [1:0]        status_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [7:0]        out_tx_byte_r;
  logic [1:0]        out_status_r;
  logic              out_run_last_r;

  logic              slot_free;
  logic              take;
  logic              store;
  logic [7:0]        sum_a_new;
  logic [7:0]        sum_b_new;
  logic [15:0]       tick_inc;
  logic              timed_out;
  logic              match_hit;
  logic [3:0]        match_next;
  logic [15:0]       ack_ck;
  logic [LEN_W-1:0]  idx_end;
  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  assign slot_free  = !out_valid_r || out_ready;
  assign cmd_pop_o  = (state_r == S_IDLE) && cmd_valid_i;
  assign take       = cmd_pop_o;
  assign store      = take && (cmd_i.op == ubxack_pkg::OP_LOAD) && (phase_r == PH_LOAD)
                      && (len_r < STORE_LIM);
  assign sum_a_new  = sum_a_r + cmd_i.data;
  assign sum_b_new  = sum_b_r + sum_a_new;
  assign tick_inc   = (tick_r != 16'hFFFF) ? tick_r + 16'd1 : tick_r;
  assign timed_out  = (tick_inc >= cfg_i.timeout_ticks);
  assign match_hit  = (cmd_i.data == ubxack_pkg::ack_byte(match_r, ack_class_r, ack_id_r,
                                                          ack_sum_a_r, ack_sum_b_r));
  assign match_next = match_r + 4'd1;
  assign ack_ck     = ubxack_pkg::ack_checksum(ack_class_r, ack_id_r);
  assign idx_end    = LEN_W'(idx_r) + LEN_W'(1);

  // Frame bytes are written on load; checksum bytes land right after them
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = cmd_i.data;
    if (store) begin
      ram_we = 1'b1;
    end else if (state_r == S_CK_A) begin
      ram_we    = slot_free;
      ram_wdata = sum_a_r;
    end else if (state_r == S_CK_B) begin
      ram_we    = slot_free;
      ram_wdata = sum_b_r;
    end
  end

  ubxack_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_MAX)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (state_r == S_RD),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LOAD;
      len_r       <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      ack_class_r <= '0;
      ack_id_r    <= '0;
      ack_sum_a_r <= '0;
      ack_sum_b_r <= '0;
      match_r     <= '0;
      tick_r      <= '0;
      attempt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (take) begin
            byte_r <= cmd_i.data;
            fend_r <= cmd_i.fend;
            case (cmd_i.op)
              ubxack_pkg::OP_LOAD: begin
                if (phase_r == PH_LOAD) begin
                  if (store) begin
                    if (len_r >= LEN_W'(2)) begin
                      sum_a_r <= sum_a_new;
                      sum_b_r <= sum_b_new;
                    end
                    if (len_r == LEN_W'(2)) begin
                      ack_class_r <= cmd_i.data;
                    end
                    if (len_r == LEN_W'(3)) begin
                      ack_id_r <= cmd_i.data;
                    end
                    len_r   <= len_r + LEN_W'(1);
                    state_r <= S_DATA;
                  end else if (cmd_i.fend) begin
                    // store full: drop the byte but still close the frame
                    state_r <= S_CK_A;
                  end
                end
              end
              ubxack_pkg::OP_RX: begin
                if (phase_r == PH_ACK) begin
                  if (match_hit) begin
                    match_r <= match_next;
                    if (match_next >= ubxack_pkg::ACK_LEN) begin
                      status_r <= ubxack_pkg::ST_ACK;
                      state_r  <= S_STATUS;
                    end
                  end else if (cfg_i.restart_on_mismatch) begin
                    match_r <= '0;
                  end else begin
                    status_r <= ubxack_pkg::ST_MISMATCH;
                    state_r  <= S_STATUS;
                  end
                end
              end
              ubxack_pkg::OP_TICK: begin
                if (phase_r == PH_ACK) begin
                  if (!timed_out) begin
                    tick_r <= tick_inc;
                  end else if (attempt_r < cfg_i.max_attempts) begin
                    attempt_r <= attempt_r + 4'd1;
                    tick_r    <= '0;
                    match_r   <= '0;
                    idx_r     <= '0;
                    state_r   <= S_RD;
                  end else begin
                    status_r <= ubxack_pkg::ST_TIMEOUT;
                    state_r  <= S_STATUS;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_DATA: begin
          if (slot_free) begin
            out_valid_r    <= 1'b1;
            out_kind_r     <= ubxack_pkg::OUT_TX;
            out_tx_byte_r  <= byte_r;
            out_status_r   <= ubxack_pkg::ST_NONE;
            out_run_last_r <= !fend_r;
            state_r        <= fend_r ? S_CK_A : S_IDLE;
          end
        end
        S_CK_A: begin
          if (slot_free) begin
            out_valid_r    <= 1'b1;
            out_kind_r     <= ubxack_pkg::OUT_TX;
            out_tx_byte_r  <= sum_a_r;
            out_status_r   <= ubxack_pkg::ST_NONE;
            out_run_last_r <= 1'b0;
            len_r          <= len_r + LEN_W'(1);
            state_r        <= S_CK_B;
          end
        end
        S_CK_B: begin
          if (slot_free) begin
            out_valid_r    <= 1'b1;
            out_kind_r     <= ubxack_pkg::OUT_TX;
            out_tx_byte_r  <= sum_b_r;
            out_status_r   <= ubxack_pkg::ST_NONE;
            out_run_last_r <= 1'b1;
            len_r          <= len_r + LEN_W'(1);
            ack_sum_a_r    <= ack_ck[7:0];
            ack_sum_b_r    <= ack_ck[15:8];
            phase_r        <= PH_ACK;
            tick_r         <= '0;
            match_r        <= '0;
            attempt_r      <= 4'd1;
            state_r        <= S_IDLE;
          end
        end
        S_RD: begin
          state_r <= S_RP;
        end
        S_RP: begin
          if (slot_free) begin
            out_valid_r    <= 1'b1;
            out_kind_r     <= ubxack_pkg::OUT_TX;
            out_tx_byte_r  <= ram_rdata;
            out_status_r   <= ubxack_pkg::ST_NONE;
            out_run_last_r <= (idx_end == len_r);
            if (idx_end == len_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + ADDR_W'(1);
              state_r <= S_RD;
            end
          end
        end
        S_STATUS: begin
          if (slot_free) begin
            out_valid_r    <= 1'b1;
            out_kind_r     <= ubxack_pkg::OUT_STATUS;
            out_tx_byte_r  <= 8'h00;
            out_status_r   <= status_r;
            out_run_last_r <= 1'b1;
            // drop the finished command and return to loading
            phase_r        <= PH_LOAD;
            len_r          <= '0;
            sum_a_r        <= '0;
            sum_b_r        <= '0;
            ack_class_r    <= '0;
            ack_id_r       <= '0;
            ack_sum_a_r    <= '0;
            ack_sum_b_r    <= '0;
            match_r        <= '0;
            tick_r         <= '0;
            attempt_r      <= '0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_tx_byte  = out_tx_byte_r;
  assign out_status   = out_status_r;
  assign out_run_last = out_run_last_r;

endmodule

`default_nettype wire
